// File: hdl/osf_pkg.sv
// ----------------------------------------------------------------------------
// osf_pkg
// Shared types, register indexes and constants of the offset spike filter.
// ----------------------------------------------------------------------------
package osf_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_GATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_SYNC   = 1'b1;

    localparam int unsigned LIMIT_W = 38;
    localparam logic [LIMIT_W-1:0] TWO_SEC_NS = 38'd2000000000;

    localparam logic [15:0] GATE_RESET = 16'd768;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic test;
        logic decide;
        logic commit;
        logic sq;
        logic acc;
        logic ms_init;
        logic mn_init;
        logic mul_step;
        logic diff;
        logic root_step;
        logic div_init;
        logic div_step;
        logic fin;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic spike;
        logic cnt_ge2;
        logic walk_last;
        logic bit_last;
        logic out_free;
    } t_stat;

    // two sync intervals in ns
    function automatic logic [LIMIT_W-1:0] f_sync_limit(input logic signed [3:0] lsi);
        logic [2:0] amt;
        begin
            amt = lsi[3] ? 3'(-lsi) : lsi[2:0];
            if (lsi == 4'sb1000) begin
                f_sync_limit = TWO_SEC_NS >> 8;
            end else if (lsi[3]) begin
                f_sync_limit = TWO_SEC_NS >> amt;
            end else begin
                f_sync_limit = TWO_SEC_NS << amt;
            end
        end
    endfunction

endpackage

// File: hdl/osf_ram.sv
// ----------------------------------------------------------------------------
// osf_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module osf_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hdl/osf_ctrl.sv
// ----------------------------------------------------------------------------
// osf_ctrl
// Sequencer: spike test, window update, window walk, squaring, root, divide.
// ----------------------------------------------------------------------------
module osf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  osf_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output osf_pkg::t_cmd  o_cmd
);

    import osf_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_TEST   = 5'd1;
    localparam logic [4:0] S_DECIDE = 5'd2;
    localparam logic [4:0] S_COMMIT = 5'd3;
    localparam logic [4:0] S_POST   = 5'd4;
    localparam logic [4:0] S_RD     = 5'd5;
    localparam logic [4:0] S_SQ     = 5'd6;
    localparam logic [4:0] S_ACC    = 5'd7;
    localparam logic [4:0] S_MSINIT = 5'd8;
    localparam logic [4:0] S_MS     = 5'd9;
    localparam logic [4:0] S_MNINIT = 5'd10;
    localparam logic [4:0] S_MN     = 5'd11;
    localparam logic [4:0] S_DIFF   = 5'd12;
    localparam logic [4:0] S_ROOT   = 5'd13;
    localparam logic [4:0] S_DINIT  = 5'd14;
    localparam logic [4:0] S_DIV    = 5'd15;
    localparam logic [4:0] S_FIN    = 5'd16;
    localparam logic [4:0] S_RESULT = 5'd17;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_TEST;
                end
            end
            S_TEST: begin
                o_cmd.test = 1'b1;
                n_state    = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_stat.spike ? S_RESULT : S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_POST;
            end
            S_POST: begin
                n_state = i_stat.cnt_ge2 ? S_RD : S_RESULT;
            end
            S_RD: begin
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_stat.walk_last ? S_MSINIT : S_RD;
            end
            S_MSINIT: begin
                o_cmd.ms_init = 1'b1;
                n_state       = S_MS;
            end
            S_MS: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.bit_last) begin
                    n_state = S_MNINIT;
                end
            end
            S_MNINIT: begin
                o_cmd.mn_init = 1'b1;
                n_state       = S_MN;
            end
            S_MN: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.bit_last) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_stat.bit_last) begin
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.bit_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: hdl/osf_dp.sv
// ----------------------------------------------------------------------------
// osf_dp
// Datapath: settings, spike test, offset window, shift-add multiplier,
// digit-by-digit square root and restoring divider, result register.
// ----------------------------------------------------------------------------
module osf_dp #(
    parameter int unsigned WINDOW_DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [osf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [osf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic signed [31:0]              i_offset_ns,
    input  logic [63:0]                     i_now_ns,
    input  logic                            i_servo_locked,
    input  logic                            i_out_ready,
    input  osf_pkg::t_cmd                   i_cmd,
    output osf_pkg::t_stat                  o_stat,
    output logic                            o_out_valid,
    output logic                            o_rejected,
    output logic [31:0]                     o_jitter_ns
);

    import osf_pkg::*;

    localparam int unsigned IW   = $clog2(WINDOW_DEPTH);
    localparam int unsigned CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned SUMW = 32 + CW;
    localparam int unsigned SQW  = 62 + CW;
    localparam int unsigned DW   = SQW + CW;
    localparam int unsigned RW   = DW / 2;
    localparam int unsigned BW   = $clog2(SUMW);

    // settings
    logic [15:0]       r_gate;
    logic signed [3:0] r_lsi;

    // input word
    logic signed [31:0] r_off;
    logic [63:0]        r_now;
    logic               r_lock;

    // filter state
    logic [IW-1:0]      r_widx;
    logic [CW-1:0]      r_count;
    logic [31:0]        r_jit;
    logic signed [31:0] r_prev_off;
    logic [63:0]        r_prev_time;

    // spike test
    logic [32:0] r_delta;
    logic [47:0] r_prod;
    logic        r_within;
    logic        r_test_en;
    logic        r_rej;

    // window walk
    logic [IW-1:0]          r_idx;
    logic signed [SUMW-1:0] r_sum;
    logic [SQW-1:0]         r_sumsq;
    logic [63:0]            r_sq;
    logic [31:0]            w_rdata;

    // shift-add multiplier, root, divider
    logic [DW-1:0]   r_ma;
    logic [SUMW-1:0] r_mb;
    logic [DW-1:0]   r_pacc;
    logic [DW-1:0]   r_s2;
    logic [BW-1:0]   r_bit;
    logic [DW-1:0]   r_rad;
    logic [RW+1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [CW-1:0]   r_drem;

    logic [32:0]     w_diff;
    logic [32:0]     w_delta;
    logic [63:0]     w_dt;
    logic [31:0]     w_xmag;
    logic [SUMW-1:0] w_smag;
    logic [RW+3:0]   w_rem_sh;
    logic [RW+3:0]   w_trial;
    logic            w_rge;
    logic [CW:0]     w_dt_sh;
    logic            w_dge;
    logic [CW-1:0]   w_count_inc;

    assign w_diff  = {r_off[31], r_off} - {r_prev_off[31], r_prev_off};
    assign w_delta = w_diff[32] ? (33'd0 - w_diff) : w_diff;
    assign w_dt    = r_now - r_prev_time;
    assign w_xmag  = w_rdata[31] ? (32'd0 - w_rdata) : w_rdata;
    assign w_smag  = r_sum[SUMW-1] ? SUMW'(-r_sum) : SUMW'(r_sum);

    assign w_rem_sh = {r_rem, r_rad[DW-1 -: 2]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_rge    = (w_rem_sh >= w_trial);

    assign w_dt_sh = {r_drem, r_root[RW-1]};
    assign w_dge   = (w_dt_sh >= {1'b0, r_count});

    assign w_count_inc = (r_count == CW'(WINDOW_DEPTH)) ? r_count : r_count + 1'b1;

    osf_ram #(
        .WIDTH (32),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (r_widx),
        .i_wdata (r_off),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate      <= GATE_RESET;
            r_lsi       <= 4'sd0;
            r_widx      <= '0;
            r_count     <= '0;
            r_jit       <= '0;
            r_prev_off  <= '0;
            r_prev_time <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SPIKE_GATE: r_gate <= i_cfg_data;
                    CFG_LOG_SYNC:   r_lsi  <= i_cfg_data[3:0];
                    default:        r_gate <= r_gate;
                endcase
            end
            if (i_cmd.commit) begin
                r_widx      <= (r_widx == IW'(WINDOW_DEPTH - 1)) ? '0 : r_widx + 1'b1;
                r_count     <= w_count_inc;
                r_prev_off  <= r_off;
                r_prev_time <= r_now;
            end
            if (i_cmd.fin) begin
                r_jit <= r_root[31:0];
            end
            if (i_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_off  <= i_offset_ns;
            r_now  <= i_now_ns;
            r_lock <= i_servo_locked;
        end
        if (i_cmd.test) begin
            r_delta   <= w_delta;
            r_prod    <= 48'(r_gate) * 48'(r_jit);
            r_within  <= w_dt[63] || (w_dt < 64'(f_sync_limit(r_lsi)));
            r_test_en <= (r_count >= CW'(2)) && r_lock;
        end
        if (i_cmd.decide) begin
            r_rej <= o_stat.spike;
        end
        if (i_cmd.commit) begin
            r_idx   <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
        end
        if (i_cmd.sq) begin
            r_sq  <= 64'(w_xmag) * 64'(w_xmag);
            r_sum <= r_sum + SUMW'($signed(w_rdata));
        end
        if (i_cmd.acc) begin
            r_sumsq <= r_sumsq + SQW'(r_sq);
            r_idx   <= r_idx + 1'b1;
        end
        if (i_cmd.ms_init) begin
            r_ma   <= DW'(w_smag);
            r_mb   <= w_smag;
            r_pacc <= '0;
            r_bit  <= BW'(SUMW - 1);
        end
        if (i_cmd.mn_init) begin
            r_s2   <= r_pacc;
            r_ma   <= DW'(r_sumsq);
            r_mb   <= SUMW'(r_count);
            r_pacc <= '0;
            r_bit  <= BW'(SUMW - 1);
        end
        if (i_cmd.mul_step) begin
            if (r_mb[0]) begin
                r_pacc <= r_pacc + r_ma;
            end
            r_ma  <= r_ma << 1;
            r_mb  <= r_mb >> 1;
            r_bit <= r_bit - 1'b1;
        end
        if (i_cmd.diff) begin
            r_rad  <= r_pacc - r_s2;
            r_rem  <= '0;
            r_root <= '0;
            r_bit  <= BW'(RW - 1);
        end
        if (i_cmd.root_step) begin
            r_rad  <= r_rad << 2;
            r_rem  <= w_rge ? (RW+2)'(w_rem_sh - w_trial) : w_rem_sh[RW+1:0];
            r_root <= {r_root[RW-2:0], w_rge};
            r_bit  <= r_bit - 1'b1;
        end
        if (i_cmd.div_init) begin
            r_drem <= '0;
            r_bit  <= BW'(RW - 1);
        end
        if (i_cmd.div_step) begin
            r_drem <= w_dge ? CW'(w_dt_sh - {1'b0, r_count}) : w_dt_sh[CW-1:0];
            r_root <= {r_root[RW-2:0], w_dge};
            r_bit  <= r_bit - 1'b1;
        end
        if (i_cmd.out_load) begin
            o_rejected  <= r_rej;
            o_jitter_ns <= r_jit;
        end
    end

    always_comb begin
        o_stat.spike     = r_test_en && r_within && ({7'd0, r_delta, 8'd0} > r_prod);
        o_stat.cnt_ge2   = (r_count >= CW'(2));
        o_stat.walk_last = (CW'(r_idx) == r_count - 1'b1);
        o_stat.bit_last  = (r_bit == '0);
        o_stat.out_free  = !o_out_valid || i_out_ready;
    end

endmodule

// File: hdl/offset_spike_filter_top.sv
// ----------------------------------------------------------------------------
// offset_spike_filter_top
// Popcorn spike suppressor for clock offset samples with windowed jitter.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------
//  input    | i_in_valid / o_in_ready  | i_offset_ns, i_now_ns, i_servo_locked
//  output   | o_out_valid / i_out_ready| o_rejected, o_jitter_ns
//  config   | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
//  one word at a time; a rejected or early word skips the window walk;
//  an accepted word with two or more held samples walks the window, then runs
//  serial steps over SUMW = 32 + clog2(depth+1) and RW = 31 + clog2(depth+1) bits
//  in the serial multiplier, square root and divider sharing one counter
//  synchronous active-low reset; the window ram is not cleared
//  the result register frees the sequencer once the word is taken
// ----------------------------------------------------------------------------
module offset_spike_filter_top #(
    parameter int unsigned WINDOW_DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [osf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [osf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [31:0]              i_offset_ns,
    input  logic [63:0]                     i_now_ns,
    input  logic                            i_servo_locked,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_rejected,
    output logic [31:0]                     o_jitter_ns
);

    import osf_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    osf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    osf_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_offset_ns    (i_offset_ns),
        .i_now_ns       (i_now_ns),
        .i_servo_locked (i_servo_locked),
        .i_out_ready    (i_out_ready),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_out_valid    (o_out_valid),
        .o_rejected     (o_rejected),
        .o_jitter_ns    (o_jitter_ns)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a word is in work");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_jitter_ns) && $stable(o_rejected)))
        else $error("stalled result changed");

    a_one_cmd_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!w_cmd.load && w_stat.out_free))
        else $error("result loaded over a pending word");
`endif

endmodule

// File: bench/offset_spike_filter_top_test.sv
// ----------------------------------------------------------------------------
// offset_spike_filter_top_test
// Self-checking bench for the offset spike filter: words are sent through the
// input handshake, a predictor computes the reject flag and the windowed
// jitter, and a checker compares every output word in order.
// ----------------------------------------------------------------------------
module offset_spike_filter_top_test;

    import osf_pkg::*;

    localparam int DEPTH    = 16;
    localparam int WD_LIMIT = 20000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic signed [31:0]     i_offset_ns = '0;
    logic [63:0]            i_now_ns = '0;
    logic                   i_servo_locked = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic                   o_rejected;
    logic [31:0]            o_jitter_ns;

    typedef struct {
        logic        rejected;
        logic [31:0] jitter;
    } t_verdict;

    t_verdict    verdicts[$];
    int          n_errors = 0;
    bit          idle_on = 1'b1;
    int          quiet_cycles = 0;

    // predictor state
    logic signed [31:0] win[DEPTH];
    int                 wr_ptr, held;
    logic [31:0]        jit;
    logic signed [31:0] last_off;
    logic [63:0]        last_time;
    logic [15:0]        gate;
    logic signed [3:0]  log_si;
    logic [63:0]        clock_ns;

    offset_spike_filter_top #(.WINDOW_DEPTH(DEPTH)) u_dut (.*);

    always #2 i_clk = ~i_clk;

    function automatic logic [63:0] isqrt128(logic [127:0] v);
        logic [63:0] r, c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= v) r = c;
        end
        return r;
    endfunction

    function automatic logic [31:0] window_jitter();
        logic signed [127:0] sum, sumsq, d;
        sum = '0;
        sumsq = '0;
        for (int i = 0; i < held; i++) begin
            sum += 128'(signed'(win[i]));
            sumsq += 128'(signed'(win[i])) * 128'(signed'(win[i]));
        end
        d = sumsq * held - sum * sum;
        return 32'(isqrt128(d) / held);
    endfunction

    task automatic predict_filter(logic signed [31:0] off, logic [63:0] now, logic lk);
        logic [63:0] delta, dt, lim;
        logic        rej;
        rej = 1'b0;
        if (held >= 2 && lk) begin
            delta = 64'(off) - 64'(last_off);
            if (delta[63]) delta = -delta;
            delta = (64'(signed'(off)) - 64'(signed'(last_off)));
            if (delta[63]) delta = -delta;
            dt = now - last_time;
            if (log_si >= 0) lim = 64'd2000000000 << log_si;
            else lim = 64'd2000000000 >> (-log_si);
            if (delta * 256 > 64'(gate) * 64'(jit) && (dt[63] || dt < lim)) rej = 1'b1;
        end
        if (!rej) begin
            win[wr_ptr] = off;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            if (held < DEPTH) held++;
            if (held >= 2) jit = window_jitter();
            last_off = off;
            last_time = now;
        end
        verdicts.push_back('{rejected: rej, jitter: jit});
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        n_errors++;
    endtask

    task automatic send_word(logic signed [31:0] off, logic [63:0] now, logic lk);
        if (idle_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_offset_ns <= off;
        i_now_ns <= now;
        i_servo_locked <= lk;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_filter(off, now, lk);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (verdicts.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SPIKE_GATE) gate = val;
        else log_si = val[3:0];
    endtask

    // checker and output back-pressure
    always @(posedge i_clk) begin
        t_verdict v;
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (o_out_valid && i_out_ready) begin
                if (verdicts.size() == 0) begin
                    report("unexpected word", 0, 0);
                end else begin
                    v = verdicts.pop_front();
                    if (o_rejected !== v.rejected) report("rejected", o_rejected, v.rejected);
                    if (o_jitter_ns !== v.jitter) report("jitter_ns", o_jitter_ns, v.jitter);
                end
            end
            i_out_ready <= !(idle_on && $urandom_range(0, 4) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WD_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_warmup();
        clock_ns = 64'd1000;
        send_word(32'sd100, clock_ns, 1'b1);
        clock_ns += 64'd1000;
        send_word(32'sd120, clock_ns, 1'b1);
        clock_ns += 64'd1000;
        send_word(32'sd90, clock_ns, 1'b1);
    endtask

    task automatic test_extremes();
        send_word(32'h7fffffff, clock_ns + 10, 1'b1);
        send_word(32'h7fffffff, clock_ns + 20, 1'b0);
        send_word(32'h80000000, clock_ns + 30, 1'b0);
        send_word(32'h80000000, clock_ns + 40, 1'b1);
        send_word(32'sd0, 64'hffffffffffffffff, 1'b1);
        send_word(32'sd5, 64'd0, 1'b1);
        send_word(32'sd5, 64'h8000000000000000, 1'b1);
        clock_ns = 64'h8000000000001000;
        for (int i = 0; i < 18; i++) send_word(32'(i * 3 - 20), clock_ns + i, 1'b0);
    endtask

    task automatic test_spikes(int n);
        logic signed [31:0] base, off;
        base = signed'(32'($urandom_range(0, 2000))) - 1000;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: off = $urandom;
                1, 2: off = base + signed'(32'($urandom_range(0, 200000))) - 100000;
                default: off = base + signed'(32'($urandom_range(0, 40))) - 20;
            endcase
            case ($urandom_range(0, 9))
                0: clock_ns = {$urandom, $urandom};
                1: clock_ns -= $urandom_range(0, 1000);
                2: clock_ns += {$urandom_range(0, 15), $urandom};
                default: clock_ns += $urandom_range(1, 3000000000);
            endcase
            send_word(off, clock_ns, $urandom_range(0, 7) != 0);
        end
    endtask

    task automatic test_settings();
        write_reg(CFG_SPIKE_GATE, 16'd0);
        write_reg(CFG_LOG_SYNC, 16'(4'sd7));
        test_spikes(60);
        write_reg(CFG_SPIKE_GATE, 16'hffff);
        write_reg(CFG_LOG_SYNC, 16'(-4'sd7));
        test_spikes(60);
        write_reg(CFG_LOG_SYNC, 16'(4'sb1000));
        write_reg(CFG_SPIKE_GATE, 16'd256);
        test_spikes(60);
        for (int k = 0; k < 4; k++) begin
            write_reg(CFG_SPIKE_GATE, 16'($urandom));
            write_reg(CFG_LOG_SYNC, 16'($urandom_range(0, 15)));
            test_spikes(90);
        end
    endtask

    initial begin
        gate = GATE_RESET;
        log_si = '0;
        wr_ptr = 0;
        held = 0;
        jit = '0;
        last_off = '0;
        last_time = '0;
        for (int i = 0; i < DEPTH; i++) win[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_warmup();
        test_extremes();
        test_spikes(40);
        test_settings();
        idle_on = 1'b0;
        test_spikes(40);
        drain();
        if (n_errors == 0 && verdicts.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
